// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro takes a label, a property
// expression and a message string. The sampling clock is clk and the reset is rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check at every clock edge outside of reset.
`define DTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check at every clock edge, during reset as well.
`define DTE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTE_ASSERT(label, prop, msg)
`define DTE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/core/dte_pkg.sv =====
`default_nettype none

package dte_pkg;

    // Binary angles: 2^32 is one full turn.
    localparam int ANGLE_W = 32;
    localparam logic [ANGLE_W-1:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER = 32'hC000_0000;

    // Left shift of the components on entry to the rotator.
    localparam int GUARD_SHIFT = 24;

    // Configuration registers.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 12;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_AXIS_CONVENTION = 2'd0;
    localparam cfg_index_t CFG_IMAGE_WIDTH     = 2'd1;
    localparam cfg_index_t CFG_IMAGE_HEIGHT    = 2'd2;

    localparam logic                AXIS_RESET   = 1'b1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd512;

    // Pixel outputs, 8 fraction bits.
    localparam int COL_W     = 20;
    localparam int ROW_W     = 20;
    localparam int COL_SHIFT = 24;
    localparam int ROW_SHIFT = 23;
    localparam logic [COL_W-1:0] COL_MAX = 20'hF_FFFF;

    // Handshake of one pipeline stage toward the next.
    typedef struct packed {
        logic advance;
        logic valid;
    } stage_ctrl_t;

    // round(atan(2^-i) * 2^32 / (2pi))
    function automatic logic [ANGLE_W-1:0] atan_entry(input int unsigned idx);
        logic [ANGLE_W-1:0] ent;
        case (idx)
            0:       ent = 32'h2000_0000;
            1:       ent = 32'h12E4_051E;
            2:       ent = 32'h09FB_385B;
            3:       ent = 32'h0511_11D4;
            4:       ent = 32'h028B_0D43;
            5:       ent = 32'h0145_D7E1;
            6:       ent = 32'h00A2_F61E;
            7:       ent = 32'h0051_7C55;
            8:       ent = 32'h0028_BE53;
            9:       ent = 32'h0014_5F2F;
            10:      ent = 32'h000A_2F98;
            11:      ent = 32'h0005_17CC;
            12:      ent = 32'h0002_8BE6;
            13:      ent = 32'h0001_45F3;
            14:      ent = 32'h0000_A2FA;
            15:      ent = 32'h0000_517D;
            16:      ent = 32'h0000_28BE;
            17:      ent = 32'h0000_145F;
            18:      ent = 32'h0000_0A30;
            19:      ent = 32'h0000_0518;
            20:      ent = 32'h0000_028C;
            21:      ent = 32'h0000_0146;
            22:      ent = 32'h0000_00A3;
            23:      ent = 32'h0000_0051;
            24:      ent = 32'h0000_0029;
            25:      ent = 32'h0000_0014;
            26:      ent = 32'h0000_000A;
            27:      ent = 32'h0000_0005;
            28:      ent = 32'h0000_0003;
            29:      ent = 32'h0000_0001;
            30:      ent = 32'h0000_0001;
            default: ent = 32'h0000_0000;
        endcase
        return ent;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dte_cordic.sv =====
`default_nettype none

// Vectoring rotator: binary angle of atan2(b, a) over the full circle.
// One micro-rotation per stage, behind an input register.
module dte_cordic #(
    parameter int IN_W   = 25,
    parameter int STAGES = 20,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dte_pkg::stage_ctrl_t          in_ctrl,
    input  logic signed [IN_W-1:0]        a,
    input  logic signed [IN_W-1:0]        b,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [dte_pkg::ANGLE_W-1:0]   angle,
    output logic [SIDE_W-1:0]             side_out
);
    import dte_pkg::*;

    localparam int W = IN_W + GUARD_SHIFT + 2;

    logic signed [W-1:0]       x_reg   [0:STAGES-1];
    logic signed [W-1:0]       y_reg   [0:STAGES-1];
    logic                      fix_reg [0:STAGES-1];
    logic [ANGLE_W-1:0]        ang_reg [0:STAGES];
    logic [SIDE_W-1:0]         side_reg[0:STAGES];
    logic                      vld_reg [0:STAGES];

    logic                      a_neg;
    logic signed [IN_W-1:0]    a_abs;
    logic signed [IN_W-1:0]    b_adj;

    // Fold the left half plane onto the right half by a half-turn.
    assign a_neg = a[IN_W-1];
    assign a_abs = a_neg ? -a : a;
    assign b_adj = a_neg ? -b : b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (in_ctrl.advance)
        begin
            vld_reg[0] <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctrl.advance)
        begin
            x_reg[0]    <= {{(W-IN_W-GUARD_SHIFT){a_abs[IN_W-1]}}, a_abs,
                            {GUARD_SHIFT{1'b0}}};
            y_reg[0]    <= {{(W-IN_W-GUARD_SHIFT){b_adj[IN_W-1]}}, b_adj,
                            {GUARD_SHIFT{1'b0}}};
            // With b zero the start angle (zero or a half-turn) is the answer.
            fix_reg[0]  <= (b == '0);
            ang_reg[0]  <= a_neg ? HALF_TURN : '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic [ANGLE_W-1:0] TAB = atan_entry(i);

        logic rot_down;

        assign rot_down = y_reg[i][W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (in_ctrl.advance)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (in_ctrl.advance)
            begin
                side_reg[i+1] <= side_reg[i];
                if (fix_reg[i])
                begin
                    ang_reg[i+1] <= ang_reg[i];
                end
                else if (rot_down)
                begin
                    ang_reg[i+1] <= ang_reg[i] - TAB;
                end
                else
                begin
                    ang_reg[i+1] <= ang_reg[i] + TAB;
                end
            end
        end

        // The last stage only settles the angle.
        if (i < STAGES - 1)
        begin : g_xy
            logic signed [W-1:0] x_sh;
            logic signed [W-1:0] y_sh;

            assign x_sh = x_reg[i] >>> i;
            assign y_sh = y_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (in_ctrl.advance)
                begin
                    x_reg[i+1]   <= rot_down ? (x_reg[i] - y_sh) : (x_reg[i] + y_sh);
                    y_reg[i+1]   <= rot_down ? (y_reg[i] + x_sh) : (y_reg[i] - x_sh);
                    fix_reg[i+1] <= fix_reg[i];
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign angle     = ang_reg[STAGES];
    assign side_out  = side_reg[STAGES];

endmodule

`default_nettype wire

// ===== rtl/core/dte_isqrt.sv =====
`default_nettype none

// Pipelined integer square root, rounded to nearest. One root bit per
// stage plus a rounding stage.
module dte_isqrt #(
    parameter int ROOT_W = 24,
    parameter int SIDE_W = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dte_pkg::stage_ctrl_t    in_ctrl,
    input  logic [2*ROOT_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    out_valid,
    output logic [ROOT_W:0]         root,
    output logic [SIDE_W-1:0]       side_out
);
    import dte_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;

    logic [RAD_W-1:0]  rem_reg [0:ROOT_W-1];
    logic [RAD_W-1:0]  res_reg [0:ROOT_W-1];
    logic [SIDE_W-1:0] side_reg[0:ROOT_W-1];
    logic              vld_reg [0:ROOT_W-1];

    logic [ROOT_W:0]   root_reg;
    logic [SIDE_W-1:0] side_out_reg;
    logic              valid_out_reg;

    logic [ROOT_W:0]   res_last;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - k));

        logic [RAD_W-1:0]  cur_rem;
        logic [RAD_W-1:0]  cur_res;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        logic [RAD_W-1:0]  trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign cur_rem  = radicand;
            assign cur_res  = '0;
            assign cur_side = side_in;
            assign cur_vld  = in_ctrl.valid;
        end
        else
        begin : g_next
            assign cur_rem  = rem_reg[k-1];
            assign cur_res  = res_reg[k-1];
            assign cur_side = side_reg[k-1];
            assign cur_vld  = vld_reg[k-1];
        end

        assign trial = cur_res + BIT;
        assign take  = (cur_rem >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (in_ctrl.advance)
            begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (in_ctrl.advance)
            begin
                rem_reg[k]  <= take ? (cur_rem - trial) : cur_rem;
                res_reg[k]  <= take ? ((cur_res >> 1) + BIT) : (cur_res >> 1);
                side_reg[k] <= cur_side;
            end
        end
    end

    assign res_last = res_reg[ROOT_W-1][ROOT_W:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out_reg <= 1'b0;
        end
        else if (in_ctrl.advance)
        begin
            valid_out_reg <= vld_reg[ROOT_W-1];
        end
    end

    // Round up when the remainder passes the floor root.
    always_ff @(posedge clk)
    begin
        if (in_ctrl.advance)
        begin
            root_reg     <= (rem_reg[ROOT_W-1] > res_reg[ROOT_W-1])
                            ? (res_last + (ROOT_W+1)'(1)) : res_last;
            side_out_reg <= side_reg[ROOT_W-1];
        end
    end

    assign out_valid = valid_out_reg;
    assign root      = root_reg;
    assign side_out  = side_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/direction_to_equirect_pixel_unit.sv =====
`default_nettype none

`include "assert_macros.svh"

// Maps a 3D direction (dir_x, dir_y, dir_z) onto an equirectangular
// panorama and returns the pixel in 1/256 pixel units: pixel_col is the
// azimuth atan2(y, x) over a full turn times image_width, pixel_row is the
// zenith atan2(sqrt(x^2 + y^2), z) over a half-turn times image_height,
// rounded. azimuth_undefined flags a direction on the vertical axis, where
// the column is 0; the zero vector also gives row 0. axis_convention 1
// negates x, 0 swaps x and y and then negates the new y. The unit takes one
// transaction per clock while in_ready is high and runs fully pipelined:
// two vectoring rotators of CORDIC_STAGES stages each and a root extractor
// of COMPONENT_BITS stages make up most of the pipeline from acceptance to
// out_valid. A stalled output holds one result in the output register and
// one in a skid register; in_ready drops only while the skid register is
// full, and the whole pipeline then holds in place. Configuration writes
// are accepted every cycle. axis_convention is applied as a transaction is
// accepted, while image_width and image_height are read at the scaling
// stage, ahead of the rounding and output registers, so a write also lands
// on transactions already in flight; write them only while the unit is
// empty.
module direction_to_equirect_pixel_unit #(
    parameter int COMPONENT_BITS = 24,
    parameter int CORDIC_STAGES  = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COMPONENT_BITS-1:0]    dir_x,
    input  logic signed [COMPONENT_BITS-1:0]    dir_y,
    input  logic signed [COMPONENT_BITS-1:0]    dir_z,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dte_pkg::COL_W-1:0]           pixel_col,
    output logic [dte_pkg::ROW_W-1:0]           pixel_row,
    output logic                                azimuth_undefined,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dte_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dte_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dte_pkg::*;

    localparam int CB         = COMPONENT_BITS;
    localparam int IN_W       = CB + 1;
    localparam int SUM_W      = 2 * CB;
    localparam int AZ_SIDE_W  = 2 * IN_W + CB + 1;
    localparam int RT_SIDE_W  = ANGLE_W + CB + 1;
    localparam int ZN_SIDE_W  = ANGLE_W + 1;
    localparam int COL_PROD_W = ANGLE_W + WIDTH_W;
    localparam int ROW_PROD_W = ANGLE_W + HEIGHT_W;
    localparam logic [ROW_PROD_W-1:0] ROW_HALF = ROW_PROD_W'(1) << (ROW_SHIFT - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                axis_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg         <= AXIS_RESET;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AXIS_CONVENTION: axis_reg         <= cfg_data[0];
                CFG_IMAGE_WIDTH:     image_width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:    image_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:             ;  // drop writes to unknown registers
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the skid
    // register already holds a result.
    // ------------------------------------------------------------------
    logic skid_full_reg;
    logic en;

    assign en       = !skid_full_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stage 0: sign-extend and apply the axis convention
    // ------------------------------------------------------------------
    logic signed [IN_W-1:0] ix;
    logic signed [IN_W-1:0] iy;
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;

    logic                   s0_valid_reg;
    logic signed [IN_W-1:0] s0_x_reg;
    logic signed [IN_W-1:0] s0_y_reg;
    logic signed [CB-1:0]   s0_z_reg;
    logic                   s0_undef_reg;

    assign ix = {dir_x[CB-1], dir_x};
    assign iy = {dir_y[CB-1], dir_y};
    assign px = axis_reg ? -ix : iy;
    assign py = axis_reg ? iy : -ix;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg     <= px;
            s0_y_reg     <= py;
            s0_z_reg     <= dir_z;
            s0_undef_reg <= (px == '0) && (py == '0);
        end
    end

    // ------------------------------------------------------------------
    // Azimuth rotator: atan2(y', x'); a direction on the vertical axis gives 0.
    // ------------------------------------------------------------------
    logic                   az_valid;
    logic [ANGLE_W-1:0]     az_angle;
    logic [AZ_SIDE_W-1:0]   az_side;
    logic signed [IN_W-1:0] az_x;
    logic signed [IN_W-1:0] az_y;
    logic signed [CB-1:0]   az_z;
    logic                   az_undef;

    dte_cordic #(
        .IN_W   (IN_W),
        .STAGES (CORDIC_STAGES),
        .SIDE_W (AZ_SIDE_W)
    ) u_az_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   ('{advance: en, valid: s0_valid_reg}),
        .a         (s0_x_reg),
        .b         (s0_y_reg),
        .side_in   ({s0_x_reg, s0_y_reg, s0_z_reg, s0_undef_reg}),
        .out_valid (az_valid),
        .angle     (az_angle),
        .side_out  (az_side)
    );

    assign {az_x, az_y, az_z, az_undef} = az_side;

    // ------------------------------------------------------------------
    // Squares, then their sum
    // ------------------------------------------------------------------
    logic signed [2*IN_W-1:0] sq_x_full;
    logic signed [2*IN_W-1:0] sq_y_full;

    logic                 s1_valid_reg;
    logic [SUM_W-1:0]     sq_x_reg;
    logic [SUM_W-1:0]     sq_y_reg;
    logic [ANGLE_W-1:0]   s1_az_reg;
    logic signed [CB-1:0] s1_z_reg;
    logic                 s1_undef_reg;

    logic                 s2_valid_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [ANGLE_W-1:0]   s2_az_reg;
    logic signed [CB-1:0] s2_z_reg;
    logic                 s2_undef_reg;

    assign sq_x_full = az_x * az_x;
    assign sq_y_full = az_y * az_y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg     <= sq_x_full[SUM_W-1:0];
            sq_y_reg     <= sq_y_full[SUM_W-1:0];
            s1_az_reg    <= az_angle;
            s1_z_reg     <= az_z;
            s1_undef_reg <= az_undef;

            sum_reg      <= sq_x_reg + sq_y_reg;
            s2_az_reg    <= s1_az_reg;
            s2_z_reg     <= s1_z_reg;
            s2_undef_reg <= s1_undef_reg;
        end
    end

    // ------------------------------------------------------------------
    // Horizontal radius, rounded to nearest
    // ------------------------------------------------------------------
    logic                 rt_valid;
    logic [CB:0]          rt_root;
    logic [RT_SIDE_W-1:0] rt_side;
    logic [ANGLE_W-1:0]   rt_az;
    logic signed [CB-1:0] rt_z;
    logic                 rt_undef;

    dte_isqrt #(
        .ROOT_W (CB),
        .SIDE_W (RT_SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   ('{advance: en, valid: s2_valid_reg}),
        .radicand  (sum_reg),
        .side_in   ({s2_az_reg, s2_z_reg, s2_undef_reg}),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    assign {rt_az, rt_z, rt_undef} = rt_side;

    // ------------------------------------------------------------------
    // Zenith rotator: atan2(r, z); the zero vector lands on angle 0.
    // ------------------------------------------------------------------
    logic                 zn_valid;
    logic [ANGLE_W-1:0]   zn_angle;
    logic [ZN_SIDE_W-1:0] zn_side;
    logic [ANGLE_W-1:0]   zn_az;
    logic                 zn_undef;

    dte_cordic #(
        .IN_W   (IN_W),
        .STAGES (CORDIC_STAGES),
        .SIDE_W (ZN_SIDE_W)
    ) u_zen_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   ('{advance: en, valid: rt_valid}),
        .a         ({rt_z[CB-1], rt_z}),
        .b         ($signed(rt_root)),
        .side_in   ({rt_az, rt_undef}),
        .out_valid (zn_valid),
        .angle     (zn_angle),
        .side_out  (zn_side)
    );

    assign {zn_az, zn_undef} = zn_side;

    // ------------------------------------------------------------------
    // Clamp zenith to [0, half-turn], scale, then saturate and round
    // ------------------------------------------------------------------
    logic                  cl_valid_reg;
    logic [ANGLE_W-1:0]    cl_zen_reg;
    logic [ANGLE_W-1:0]    cl_az_reg;
    logic                  cl_undef_reg;

    logic                  pr_valid_reg;
    logic [COL_PROD_W-1:0] col_prod_reg;
    logic [ROW_PROD_W-1:0] row_prod_reg;
    logic                  pr_undef_reg;

    logic [ROW_PROD_W-1:0] row_sum;

    logic                  fin_valid_reg;
    logic [COL_W-1:0]      fin_col_reg;
    logic [ROW_W-1:0]      fin_row_reg;
    logic                  fin_undef_reg;

    assign row_sum = row_prod_reg + ROW_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Past a half-turn the small overshoot near zero wraps back to 0;
            // the rest snaps to a half-turn.
            if (zn_angle > HALF_TURN)
            begin
                cl_zen_reg <= (zn_angle >= THREE_QUARTER) ? '0 : HALF_TURN;
            end
            else
            begin
                cl_zen_reg <= zn_angle;
            end
            cl_az_reg     <= zn_az;
            cl_undef_reg  <= zn_undef;

            col_prod_reg  <= COL_PROD_W'(cl_az_reg) * COL_PROD_W'(image_width_reg);
            row_prod_reg  <= ROW_PROD_W'(cl_zen_reg) * ROW_PROD_W'(image_height_reg);
            pr_undef_reg  <= cl_undef_reg;

            fin_col_reg   <= (|col_prod_reg[COL_PROD_W-1:COL_SHIFT+COL_W])
                             ? COL_MAX : col_prod_reg[COL_SHIFT+COL_W-1:COL_SHIFT];
            fin_row_reg   <= row_sum[ROW_SHIFT+ROW_W-1:ROW_SHIFT];
            fin_undef_reg <= pr_undef_reg;
        end
    end

    // Valid bits of the stages owned by this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            cl_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= az_valid;
            s2_valid_reg  <= s1_valid_reg;
            cl_valid_reg  <= zn_valid;
            pr_valid_reg  <= cl_valid_reg;
            fin_valid_reg <= pr_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid register
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_full_next;
    logic             pop;
    logic             load_out;
    logic             load_skid;
    logic             out_from_skid;

    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             out_undef_reg;
    logic [COL_W-1:0] skid_col_reg;
    logic [ROW_W-1:0] skid_row_reg;
    logic             skid_undef_reg;

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_out       = 1'b0;
        load_skid      = 1'b0;
        out_from_skid  = 1'b0;
        if (skid_full_reg)
        begin
            // Pipeline is frozen; drain the skid register first.
            if (pop)
            begin
                skid_full_next = 1'b0;
                out_from_skid  = 1'b1;
            end
        end
        else if (fin_valid_reg)
        begin
            if (!out_valid_reg || pop)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                // Output is stalled: park the result leaving the pipeline.
                load_skid      = 1'b1;
                skid_full_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_col_reg   <= skid_col_reg;
            out_row_reg   <= skid_row_reg;
            out_undef_reg <= skid_undef_reg;
        end
        else if (load_out)
        begin
            out_col_reg   <= fin_col_reg;
            out_row_reg   <= fin_row_reg;
            out_undef_reg <= fin_undef_reg;
        end
        if (load_skid)
        begin
            skid_col_reg   <= fin_col_reg;
            skid_row_reg   <= fin_row_reg;
            skid_undef_reg <= fin_undef_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pixel_col         = out_col_reg;
    assign pixel_row         = out_row_reg;
    assign azimuth_undefined = out_undef_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DTE_ASSERT_ALWAYS(a_skid_needs_out, skid_full_reg |-> out_valid_reg, "skid full while output empty")
    `DTE_ASSERT(a_stall_parks, (out_valid_reg && !out_ready && !skid_full_reg && fin_valid_reg) |=> skid_full_reg, "stalled result not parked in skid register")
    `DTE_ASSERT(a_undef_col_zero, (out_valid_reg && azimuth_undefined) |-> (pixel_col == '0), "undefined azimuth with nonzero column")
    `DTE_ASSERT(a_row_in_image, out_valid_reg |-> (pixel_row <= {image_height_reg, 8'd0}), "row beyond image height")

endmodule

`default_nettype wire

// ===== sim/direction_to_equirect_pixel_unit_tb.sv =====
`timescale 1ns / 1ps

module direction_to_equirect_pixel_unit_tb;

    import dte_pkg::*;

    // Keep the datapath at the unit's default build.
    localparam int COMP_W         = 24;
    localparam int STAGES         = 20;
    // Two rotators, the root extractor and the glue registers.
    localparam int PIPE_LATENCY   = 2 * STAGES + COMP_W + 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 152;
    localparam int DIRECTED_ROWS  = 20;

    // The register map leaves index 3 open; writes there must be dropped.
    localparam cfg_index_t CFG_UNMAPPED = 2'd3;

    localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
    localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W - 1){1'b0}}};

    // Micro-rotation angles as binary angles, one per vectoring stage.
    localparam logic [ANGLE_W-1:0] ATAN_LUT [STAGES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518
    };

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             undef_az;
    } pixel_t;

    // One directed transaction; a typed row carries its pixel, the rest go
    // through the predictor.
    typedef struct packed {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic              typed;
        pixel_t            want;
    } directed_row_t;

    typedef enum {
        DIR_FULL,
        DIR_SCALED,
        DIR_TINY,
        DIR_AXIS,
        DIR_POLE,
        DIR_EXTREME,
        DIR_NEAR_POLE
    } dir_kind_t;

    typedef enum {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_STARVED
    } stall_mode_t;

    // Directed rows run under the reset configuration (x negated, 1024 x 512).
    // A direction on the vertical axis has a known column and flag; straight
    // down lands on the half-turn row, 512 * 256 = 131072.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{24'sd0,   24'sd0,   24'sd0,    1'b1, '{20'd0, 20'd0,      1'b1}},
        '{24'sd0,   24'sd0,   24'sd1,    1'b1, '{20'd0, 20'd0,      1'b1}},
        '{24'sd0,   24'sd0,   -24'sd1,   1'b1, '{20'd0, 20'd131072, 1'b1}},
        '{24'sd0,   24'sd0,   COMP_MAX,  1'b1, '{20'd0, 20'd0,      1'b1}},
        '{24'sd0,   24'sd0,   COMP_MIN,  1'b1, '{20'd0, 20'd131072, 1'b1}},
        '{24'sd1,   24'sd0,   24'sd0,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{-24'sd1,  24'sd0,   24'sd0,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{24'sd0,   24'sd1,   24'sd0,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{24'sd0,   -24'sd1,  24'sd0,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{COMP_MAX, COMP_MAX, COMP_MAX,  1'b0, '{20'd0, 20'd0,      1'b0}},
        '{COMP_MIN, COMP_MIN, COMP_MIN,  1'b0, '{20'd0, 20'd0,      1'b0}},
        '{COMP_MIN, COMP_MAX, 24'sd0,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{COMP_MAX, COMP_MIN, COMP_MIN,  1'b0, '{20'd0, 20'd0,      1'b0}},
        '{COMP_MIN, 24'sd0,   24'sd5,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{24'sd0,   COMP_MIN, COMP_MAX,  1'b0, '{20'd0, 20'd0,      1'b0}},
        '{24'sd1000, 24'sd0,  24'sd1000, 1'b0, '{20'd0, 20'd0,      1'b0}},
        '{-24'sd5,  -24'sd5,  24'sd5,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{24'sd123456, -24'sd654321, -24'sd111111, 1'b0, '{20'd0, 20'd0, 1'b0}},
        '{24'sd1,   24'sd1,   24'sd1,    1'b0, '{20'd0, 20'd0,      1'b0}},
        '{-24'sd1,  -24'sd1,  -24'sd1,   1'b0, '{20'd0, 20'd0,      1'b0}}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic signed [COMP_W-1:0]        dir_x;
    logic signed [COMP_W-1:0]        dir_y;
    logic signed [COMP_W-1:0]        dir_z;
    logic                            out_valid;
    logic                            out_ready;
    logic [COL_W-1:0]                pixel_col;
    logic [ROW_W-1:0]                pixel_row;
    logic                            azimuth_undefined;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [CFG_INDEX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]           cfg_data;

    // Configuration as the predictor sees it, updated at each accepted write.
    logic                            axis_conv;
    logic [WIDTH_W-1:0]              model_width;
    logic [HEIGHT_W-1:0]             model_height;

    pixel_t                          pending_pixels [$];
    int                              mismatches;
    int                              results_checked;
    int                              quiet_cycles;
    int                              burst_left;

    direction_to_equirect_pixel_unit #(
        .COMPONENT_BITS (COMP_W),
        .CORDIC_STAGES  (STAGES)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .dir_x             (dir_x),
        .dir_y             (dir_y),
        .dir_z             (dir_z),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pixel_col         (pixel_col),
        .pixel_row         (pixel_row),
        .azimuth_undefined (azimuth_undefined),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Binary angle of atan2(b, a) over the full circle, wrapping modulo 2^32.
    // Vectoring drives b toward zero; an operand pair with b zero is exact.
    function automatic logic [ANGLE_W-1:0] binary_angle(input longint a, input longint b);
        longint               vx;
        longint               vy;
        longint               nx;
        logic [ANGLE_W-1:0]   ang;
        int                   i;
        ang = '0;
        if (b == 0)
            return (a >= 0) ? '0 : HALF_TURN;
        // Fold the left half-plane over so the rotator only sees a >= 0.
        if (a < 0)
        begin
            a   = -a;
            b   = -b;
            ang = HALF_TURN;
        end
        vx = a <<< GUARD_SHIFT;
        vy = b <<< GUARD_SHIFT;
        for (i = 0; i < STAGES; i++)
        begin
            // Arithmetic shifts floor toward minus infinity, as the rotator does.
            if (vy >= 0)
            begin
                nx  = vx + (vy >>> i);
                vy  = vy - (vx >>> i);
                ang = ang + ATAN_LUT[i];
            end
            else
            begin
                nx  = vx - (vy >>> i);
                vy  = vy + (vx >>> i);
                ang = ang - ATAN_LUT[i];
            end
            vx = nx;
        end
        return ang;
    endfunction

    // Expected pixel for one direction under the current configuration.
    function automatic pixel_t predict_pixel(input logic signed [COMP_W-1:0] x,
                                             input logic signed [COMP_W-1:0] y,
                                             input logic signed [COMP_W-1:0] z);
        longint               ix;
        longint               iy;
        longint               iz;
        longint               px;
        longint               py;
        longint unsigned      ax;
        longint unsigned      ay;
        longint unsigned      rem;
        longint unsigned      root;
        longint unsigned      probe;
        longint unsigned      wide;
        logic [ANGLE_W-1:0]   az;
        logic [ANGLE_W-1:0]   zen;
        pixel_t               pix;
        ix = x;
        iy = y;
        iz = z;
        if (axis_conv)
        begin
            px = -ix;
            py = iy;
        end
        else
        begin
            px = iy;
            py = -ix;
        end
        pix.undef_az = (px == 0) && (py == 0);
        az  = pix.undef_az ? '0 : binary_angle(px, py);

        // Horizontal radius: integer square root, rounded to nearest.
        ax    = (px < 0) ? -px : px;
        ay    = (py < 0) ? -py : py;
        rem   = ax * ax + ay * ay;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        if (rem > root)
            root = root + 1;

        // The zero vector pins the zenith to 0; otherwise clamp to [0, pi].
        zen = '0;
        if (!(pix.undef_az && iz == 0))
        begin
            zen = binary_angle(iz, longint'(root));
            if (zen > HALF_TURN)
                zen = (zen >= THREE_QUARTER) ? '0 : HALF_TURN;
        end

        wide = az;
        wide = (wide * model_width) >> COL_SHIFT;
        pix.col = (wide > COL_MAX) ? COL_MAX : wide[COL_W-1:0];
        wide = zen;
        wide = (wide * model_height + (64'd1 << (ROW_SHIFT - 1))) >> ROW_SHIFT;
        pix.row = wide[ROW_W-1:0];
        return pix;
    endfunction

    function automatic logic signed [COMP_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return COMP_MAX;
            1:       return COMP_MIN;
            2:       return 24'sd1;
            3:       return -24'sd1;
            default: return 24'sd0;
        endcase
    endfunction

    // Present one direction, hold it until accepted, then log its pixel.
    // Between bursts drop valid for a random gap; within a burst keep valid
    // high so the next transaction follows back to back.
    task automatic send_direction(input logic signed [COMP_W-1:0] x,
                                  input logic signed [COMP_W-1:0] y,
                                  input logic signed [COMP_W-1:0] z,
                                  input logic typed,
                                  input pixel_t typed_pixel);
        dir_x    <= x;
        dir_y    <= y;
        dir_z    <= z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pixels.insert(pending_pixels.size(),
                              typed ? typed_pixel : predict_pixel(x, y, z));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
            // Mostly short bursts; now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Hold off the sender until every pixel in flight has come back.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Write one register and mirror it into the predictor's copy. Valid stays
    // high on return; the caller drops it after the last write.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_AXIS_CONVENTION: axis_conv    = data[0];
            CFG_IMAGE_WIDTH:     model_width  = data[WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT:    model_height = data[HEIGHT_W-1:0];
            default:             ;
        endcase
    endtask

    // Receiver: switch between always ready, random stalls, a fixed duty
    // cycle and long starvation, each for a random span.
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          tick;
        out_ready = 1'b0;
        tick      = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    READY_ALWAYS:   out_ready <= 1'b1;
                    READY_RANDOM:   out_ready <= ($urandom_range(0, 2) != 0);
                    READY_PERIODIC: out_ready <= ((tick % 8) < 5);
                    default:        out_ready <= ((tick % 16) >= 12);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest pixel in flight.
    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.col      = pixel_col;
            got.row      = pixel_row;
            got.undef_az = azimuth_undefined;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing in flight: col=%0d row=%0d undef=%0b",
                             got.col, got.row, got.undef_az);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d: expected col=%0d row=%0d undef=%0b,",
                                  " got col=%0d row=%0d undef=%0b"},
                                 results_checked, want.col, want.row, want.undef_az,
                                 got.col, got.row, got.undef_az);
                end
            end
            results_checked++;
        end
    end

    // Count cycles in which no transaction moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int                       phase;
        int                       n;
        int                       shift;
        dir_kind_t                kind;
        logic signed [COMP_W-1:0] rx;
        logic signed [COMP_W-1:0] ry;
        logic signed [COMP_W-1:0] rz;

        // Drive every input to a known value from time zero.
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        dir_x           = '0;
        dir_y           = '0;
        dir_z           = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_AXIS_CONVENTION;
        cfg_data        = '0;
        axis_conv       = AXIS_RESET;
        model_width     = WIDTH_RESET;
        model_height    = HEIGHT_RESET;
        mismatches      = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        burst_left      = 8;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under the reset configuration.
        for (n = 0; n < DIRECTED_ROWS; n++)
            send_direction(DIRECTED[n].x, DIRECTED[n].y, DIRECTED[n].z,
                           DIRECTED[n].typed, DIRECTED[n].want);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Retune only with the pipeline empty; this is also where the
            // sender sits out until every pixel has come back.
            drain_pipeline();
            case (phase)
                0:
                begin
                    // Widest image: the column saturates. Upper data bits of
                    // the one-bit and 12-bit registers must be ignored.
                    write_register(CFG_AXIS_CONVENTION, 13'h1FFE);
                    write_register(CFG_IMAGE_WIDTH, 13'h1FFF);
                    write_register(CFG_IMAGE_HEIGHT, 13'h1FFF);
                end
                1:
                begin
                    write_register(CFG_AXIS_CONVENTION, 13'h0001);
                    write_register(CFG_IMAGE_WIDTH, 13'h0000);
                    write_register(CFG_IMAGE_HEIGHT, 13'h0000);
                end
                2:
                begin
                    write_register(CFG_AXIS_CONVENTION, 13'h0000);
                    write_register(CFG_IMAGE_WIDTH, 13'd1);
                    write_register(CFG_IMAGE_HEIGHT, 13'd1);
                end
                3:
                begin
                    write_register(CFG_AXIS_CONVENTION, 13'h0AAB);
                    write_register(CFG_IMAGE_WIDTH, 13'd4096);
                    write_register(CFG_IMAGE_HEIGHT, 13'd2048);
                end
                4:
                begin
                    // Nothing lives at the open index; the setting must stay.
                    write_register(CFG_UNMAPPED, 13'h1FFF);
                    write_register(CFG_UNMAPPED, 13'h0000);
                    write_register(CFG_AXIS_CONVENTION, 13'h1554);
                end
                default:
                begin
                    write_register(CFG_AXIS_CONVENTION, CFG_DATA_W'($urandom));
                    write_register(CFG_IMAGE_WIDTH, ($urandom_range(0, 3) == 0) ?
                                   CFG_DATA_W'($urandom) :
                                   CFG_DATA_W'($urandom_range(1, 4096)));
                    write_register(CFG_IMAGE_HEIGHT, ($urandom_range(0, 3) == 0) ?
                                   CFG_DATA_W'($urandom) :
                                   CFG_DATA_W'($urandom_range(1, 2048)));
                end
            endcase
            cfg_valid <= 1'b0;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                rx    = COMP_W'($urandom);
                ry    = COMP_W'($urandom);
                rz    = COMP_W'($urandom);
                shift = $urandom_range(0, 9);
                kind  = (shift < 4) ? DIR_FULL : dir_kind_t'(shift - 3);
                case (kind)
                    DIR_SCALED:
                    begin
                        // Same direction at a smaller common scale.
                        shift = $urandom_range(1, 22);
                        rx    = rx >>> shift;
                        ry    = ry >>> shift;
                        rz    = rz >>> shift;
                    end
                    DIR_TINY:
                    begin
                        rx = rx >>> 20;
                        ry = ry >>> 20;
                        rz = rz >>> 20;
                    end
                    DIR_AXIS:
                    begin
                        // On an azimuth axis, sometimes on the horizon too.
                        if ($urandom_range(0, 1) == 0)
                            rx = '0;
                        else
                            ry = '0;
                        if ($urandom_range(0, 2) == 0)
                            rz = '0;
                    end
                    DIR_POLE:
                    begin
                        rx = '0;
                        ry = '0;
                        if ($urandom_range(0, 3) == 0)
                            rz = '0;
                    end
                    DIR_EXTREME:
                    begin
                        rx = pick_extreme();
                        ry = pick_extreme();
                        rz = pick_extreme();
                    end
                    DIR_NEAR_POLE:
                    begin
                        shift = $urandom_range(10, 22);
                        rx    = rx >>> shift;
                        ry    = ry >>> shift;
                    end
                    default:
                        ;
                endcase
                send_direction(rx, ry, rz, 1'b0, '0);
            end
        end

        // Let the last pixels drain, then idle on so that anything stray can
        // show up.
        drain_pipeline();
        repeat (2 * PIPE_LATENCY)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
